/* hw/rtl/bzs_pkg.sv */
`default_nettype none

package bzs_pkg;

    localparam int COORD_W    = 16;
    localparam int NUM_STAGES = 7;

    // pipeline stage positions
    localparam int ST_IN     = 0;
    localparam int ST_L1_MUL = 1;
    localparam int ST_L1_SUM = 2;
    localparam int ST_L2_MUL = 3;
    localparam int ST_L2_SUM = 4;
    localparam int ST_L3_MUL = 5;
    localparam int ST_OUT    = 6;

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] vld;
    } t_pipe_ctl;

endpackage

`default_nettype wire

/* hw/rtl/bzs_lerp.sv */
`default_nettype none

module bzs_lerp #(
    parameter int FRAC_BITS = 15
) (
    input  wire                       i_clk,
    input  wire                       i_en_mul,
    input  wire                       i_en_sum,
    input  wire bzs_pkg::t_coord      i_a,
    input  wire bzs_pkg::t_coord      i_b,
    input  wire [FRAC_BITS:0]         i_t,
    input  wire [FRAC_BITS:0]         i_omt,
    output bzs_pkg::t_coord           o_q
);

    localparam int TW = FRAC_BITS + 1;
    localparam int PW = bzs_pkg::COORD_W + TW;
    localparam int SW = PW + 1;
    localparam logic [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic [PW-1:0]   r_pa;
    logic [PW-1:0]   r_pb;
    logic [SW-1:0]   n_sum;
    bzs_pkg::t_coord r_q;

    // a*(1-t) and b*t side by side
    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_pa <= PW'(i_a) * PW'(i_omt);
            r_pb <= PW'(i_b) * PW'(i_t);
        end
    end

    // round to nearest, halves up
    assign n_sum = SW'(r_pa) + SW'(r_pb) + HALF;

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_q <= n_sum[FRAC_BITS +: bzs_pkg::COORD_W];
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

/* hw/rtl/bzs_pipe_ctrl.sv */
`default_nettype none

module bzs_pipe_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire                 i_stall,
    output logic                o_stall,
    output bzs_pkg::t_pipe_ctl  o_ctl
);

    localparam int NS = bzs_pkg::NUM_STAGES;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] en;

    // a stage may load when it is empty or its contents move on
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall   = !en[0];
    assign o_ctl.en  = en;
    assign o_ctl.vld = r_vld;

`ifndef NO_ASSERTIONS
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted transaction did not enter first stage");

    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS-1] && i_stall) |=> r_vld[NS-1])
        else $error("stalled result dropped");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && i_stall) |-> o_stall)
        else $error("full pipeline accepted a transaction under stall");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && en[1]) |=> r_vld[1])
        else $error("transaction lost between first stages");
`endif

endmodule

`default_nettype wire

/* hw/rtl/cubic_bezier_subdivide_unit.sv */
`default_nettype none

// channel   direction  handshake             payload
// input     in         i_valid / o_stall     i_start_*, i_ctrl_a_*, i_ctrl_b_*, i_finish_*,
//                                            i_split_t
// output    out        o_valid / i_stall     o_curve_*, o_left_*, o_right_*
//
// one transaction per cycle sustained while i_stall is low
// stages: input register, then three lerp levels of one multiply and one round stage each
// synchronous active-low reset clears only the stage valid bits
// a stall holds full stages with no bubble ahead, lets empty stages fill; bubbles collapse

module cubic_bezier_subdivide_unit #(
    parameter int FRAC_BITS = 15
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [15:0] i_start_x,
    input  wire  [15:0] i_start_y,
    input  wire  [15:0] i_ctrl_a_x,
    input  wire  [15:0] i_ctrl_a_y,
    input  wire  [15:0] i_ctrl_b_x,
    input  wire  [15:0] i_ctrl_b_y,
    input  wire  [15:0] i_finish_x,
    input  wire  [15:0] i_finish_y,
    input  wire  [15:0] i_split_t,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [15:0] o_curve_x,
    output logic [15:0] o_curve_y,
    output logic [15:0] o_left_near_x,
    output logic [15:0] o_left_near_y,
    output logic [15:0] o_left_far_x,
    output logic [15:0] o_left_far_y,
    output logic [15:0] o_right_far_x,
    output logic [15:0] o_right_far_y,
    output logic [15:0] o_right_near_x,
    output logic [15:0] o_right_near_y
);

    localparam int TW = FRAC_BITS + 1;
    localparam int CW = (TW > bzs_pkg::COORD_W) ? TW : bzs_pkg::COORD_W;
    localparam logic [CW-1:0] ONE_FIX = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;

    localparam int S_IN  = bzs_pkg::ST_IN;
    localparam int S_L1M = bzs_pkg::ST_L1_MUL;
    localparam int S_L1S = bzs_pkg::ST_L1_SUM;
    localparam int S_L2M = bzs_pkg::ST_L2_MUL;
    localparam int S_L2S = bzs_pkg::ST_L2_SUM;
    localparam int S_L3M = bzs_pkg::ST_L3_MUL;
    localparam int S_OUT = bzs_pkg::ST_OUT;

    bzs_pkg::t_pipe_ctl ctl;

    logic [CW-1:0]   t_ext;
    logic [CW-1:0]   t_sat;
    logic [TW-1:0]   n_t;
    logic [TW-1:0]   n_omt;

    logic [TW-1:0]   r_t   [S_IN:S_L2S];
    logic [TW-1:0]   r_omt [S_IN:S_L2S];
    bzs_pkg::t_coord r_pt  [4][2];

    bzs_pkg::t_coord q01  [2];
    bzs_pkg::t_coord q12  [2];
    bzs_pkg::t_coord q23  [2];
    bzs_pkg::t_coord r012 [2];
    bzs_pkg::t_coord r123 [2];
    bzs_pkg::t_coord s    [2];

    // first-level and second-level points carried alongside the later levels
    bzs_pkg::t_coord r_q01_d  [S_L2M:S_OUT][2];
    bzs_pkg::t_coord r_q23_d  [S_L2M:S_OUT][2];
    bzs_pkg::t_coord r_r012_d [S_L3M:S_OUT][2];
    bzs_pkg::t_coord r_r123_d [S_L3M:S_OUT][2];

    bzs_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_ctl   (ctl)
    );

    // t above one clamps to one
    assign t_ext = CW'(i_split_t);
    assign t_sat = (t_ext > ONE_FIX) ? ONE_FIX : t_ext;
    assign n_t   = TW'(t_sat);
    assign n_omt = TW'(ONE_FIX) - n_t;

    always_ff @(posedge i_clk) begin
        if (ctl.en[S_IN]) begin
            r_t[S_IN]   <= n_t;
            r_omt[S_IN] <= n_omt;
            r_pt[0][0]  <= i_start_x;
            r_pt[0][1]  <= i_start_y;
            r_pt[1][0]  <= i_ctrl_a_x;
            r_pt[1][1]  <= i_ctrl_a_y;
            r_pt[2][0]  <= i_ctrl_b_x;
            r_pt[2][1]  <= i_ctrl_b_y;
            r_pt[3][0]  <= i_finish_x;
            r_pt[3][1]  <= i_finish_y;
        end
        for (int k = S_IN + 1; k <= S_L2S; k++) begin
            if (ctl.en[k]) begin
                r_t[k]   <= r_t[k-1];
                r_omt[k] <= r_omt[k-1];
            end
        end
    end

    for (genvar ax = 0; ax < 2; ax++) begin : g_axis
        bzs_lerp #(.FRAC_BITS(FRAC_BITS)) u_l01 (
            .i_clk (i_clk), .i_en_mul (ctl.en[S_L1M]), .i_en_sum (ctl.en[S_L1S]),
            .i_a (r_pt[0][ax]), .i_b (r_pt[1][ax]),
            .i_t (r_t[S_IN]), .i_omt (r_omt[S_IN]), .o_q (q01[ax])
        );
        bzs_lerp #(.FRAC_BITS(FRAC_BITS)) u_l12 (
            .i_clk (i_clk), .i_en_mul (ctl.en[S_L1M]), .i_en_sum (ctl.en[S_L1S]),
            .i_a (r_pt[1][ax]), .i_b (r_pt[2][ax]),
            .i_t (r_t[S_IN]), .i_omt (r_omt[S_IN]), .o_q (q12[ax])
        );
        bzs_lerp #(.FRAC_BITS(FRAC_BITS)) u_l23 (
            .i_clk (i_clk), .i_en_mul (ctl.en[S_L1M]), .i_en_sum (ctl.en[S_L1S]),
            .i_a (r_pt[2][ax]), .i_b (r_pt[3][ax]),
            .i_t (r_t[S_IN]), .i_omt (r_omt[S_IN]), .o_q (q23[ax])
        );
        bzs_lerp #(.FRAC_BITS(FRAC_BITS)) u_l012 (
            .i_clk (i_clk), .i_en_mul (ctl.en[S_L2M]), .i_en_sum (ctl.en[S_L2S]),
            .i_a (q01[ax]), .i_b (q12[ax]),
            .i_t (r_t[S_L1S]), .i_omt (r_omt[S_L1S]), .o_q (r012[ax])
        );
        bzs_lerp #(.FRAC_BITS(FRAC_BITS)) u_l123 (
            .i_clk (i_clk), .i_en_mul (ctl.en[S_L2M]), .i_en_sum (ctl.en[S_L2S]),
            .i_a (q12[ax]), .i_b (q23[ax]),
            .i_t (r_t[S_L1S]), .i_omt (r_omt[S_L1S]), .o_q (r123[ax])
        );
        bzs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lcurve (
            .i_clk (i_clk), .i_en_mul (ctl.en[S_L3M]), .i_en_sum (ctl.en[S_OUT]),
            .i_a (r012[ax]), .i_b (r123[ax]),
            .i_t (r_t[S_L2S]), .i_omt (r_omt[S_L2S]), .o_q (s[ax])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int ax = 0; ax < 2; ax++) begin
            if (ctl.en[S_L2M]) begin
                r_q01_d[S_L2M][ax] <= q01[ax];
                r_q23_d[S_L2M][ax] <= q23[ax];
            end
            for (int k = S_L2M + 1; k <= S_OUT; k++) begin
                if (ctl.en[k]) begin
                    r_q01_d[k][ax] <= r_q01_d[k-1][ax];
                    r_q23_d[k][ax] <= r_q23_d[k-1][ax];
                end
            end
            if (ctl.en[S_L3M]) begin
                r_r012_d[S_L3M][ax] <= r012[ax];
                r_r123_d[S_L3M][ax] <= r123[ax];
            end
            if (ctl.en[S_OUT]) begin
                r_r012_d[S_OUT][ax] <= r_r012_d[S_L3M][ax];
                r_r123_d[S_OUT][ax] <= r_r123_d[S_L3M][ax];
            end
        end
    end

    assign o_valid        = ctl.vld[S_OUT];
    assign o_curve_x      = s[0];
    assign o_curve_y      = s[1];
    assign o_left_near_x  = r_q01_d[S_OUT][0];
    assign o_left_near_y  = r_q01_d[S_OUT][1];
    assign o_left_far_x   = r_r012_d[S_OUT][0];
    assign o_left_far_y   = r_r012_d[S_OUT][1];
    assign o_right_far_x  = r_r123_d[S_OUT][0];
    assign o_right_far_y  = r_r123_d[S_OUT][1];
    assign o_right_near_x = r_q23_d[S_OUT][0];
    assign o_right_near_y = r_q23_d[S_OUT][1];

endmodule

`default_nettype wire
